// File: hdl/complex_resonator_bank_assert.svh
// ----------------------------------------------------------------------------
// Complex resonator bank assertion macros
// Shared property wrappers for the resonator bank RTL.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_RESONATOR_BANK_ASSERT_SVH
`define COMPLEX_RESONATOR_BANK_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CRB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define CRB_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: hdl/crb_pkg.sv
// ----------------------------------------------------------------------------
// Resonator bank package
// Sizes, operation codes, controller/datapath command types and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crb_pkg;

    localparam int NUM_RES = 64;
    localparam int ADDR_W  = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
    localparam int IDX_W   = 6;

    // Stored words: coefficients and running state per resonator
    localparam int COEF_W  = 68;
    localparam int STATE_W = 176;

    // Iterative unit lengths
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 23;

    localparam logic [1:0] OP_SAMPLE    = 2'd0;
    localparam logic [1:0] OP_LOAD      = 2'd1;
    localparam logic [1:0] OP_STABILIZE = 2'd2;
    localparam logic [1:0] OP_READ      = 2'd3;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_LOAD,
        DP_SMP_MUL1,
        DP_SMP_MUL2,
        DP_SMP_RES,
        DP_SMP_MUL3,
        DP_SMP_WR,
        DP_SQR_Z,
        DP_SQR_RR,
        DP_SUM,
        DP_SQRT_GO,
        DP_DIV_GO,
        DP_STB_WR,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [ADDR_W-1:0]   addr;
        logic                zero;
    } dp_cmd_t;

    typedef struct packed {
        logic m_zero;
        logic sqrt_done;
        logic div_done;
    } dp_stat_t;

    function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
        return (32'(idx) < 32'(NUM_RES));
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -64'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/crb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write, then register the read word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/crb_sqrt.sv
// ----------------------------------------------------------------------------
// Integer square root unit
// Floor square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crb_sqrt
    import crb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;

    logic [35:0] rem_try;
    logic [35:0] trial;
    logic        fits;

    // Bring down two radicand bits, try subtracting 4*root+1
    always_comb begin
        rem_try = {rem_reg, rad_reg[63:62]};
        trial   = {2'b00, root_reg, 2'b01};
        fits    = (rem_try >= trial);
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQ_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Data
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg <= {rad_reg[61:0], 2'b00};
            if (fits) begin
                rem_reg  <= 34'(rem_try - trial);
                root_reg <= {root_reg[30:0], 1'b1};
            end else begin
                rem_reg  <= rem_try[33:0];
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// File: hdl/crb_div.sv
// ----------------------------------------------------------------------------
// Paired restoring divider
// Divides two numerators by one divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crb_div
    import crb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [45:0] num_a,
    input  wire logic [45:0] num_b,
    input  wire logic [23:0] den,
    output logic             done,
    output logic [22:0]      quo_a,
    output logic [22:0]      quo_b
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [23:0] rem_a_reg;
    logic [23:0] rem_b_reg;
    logic [22:0] sh_a_reg;
    logic [22:0] sh_b_reg;
    logic [22:0] quo_a_reg;
    logic [22:0] quo_b_reg;
    logic [23:0] den_reg;

    logic [24:0] try_a;
    logic [24:0] try_b;
    logic        fit_a;
    logic        fit_b;

    // Shift in the next numerator bit and compare with the divisor
    always_comb begin
        try_a = {rem_a_reg, sh_a_reg[22]};
        try_b = {rem_b_reg, sh_b_reg[22]};
        fit_a = (try_a >= {1'b0, den_reg});
        fit_b = (try_b >= {1'b0, den_reg});
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Data: the high part of each numerator is already below the divisor
    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg   <= den;
            rem_a_reg <= {1'b0, num_a[45:23]};
            rem_b_reg <= {1'b0, num_b[45:23]};
            sh_a_reg  <= num_a[22:0];
            sh_b_reg  <= num_b[22:0];
            quo_a_reg <= '0;
            quo_b_reg <= '0;
        end else if (busy_reg) begin
            sh_a_reg  <= {sh_a_reg[21:0], 1'b0};
            sh_b_reg  <= {sh_b_reg[21:0], 1'b0};
            rem_a_reg <= fit_a ? 24'(try_a - {1'b0, den_reg}) : try_a[23:0];
            rem_b_reg <= fit_b ? 24'(try_b - {1'b0, den_reg}) : try_b[23:0];
            quo_a_reg <= {quo_a_reg[21:0], fit_a};
            quo_b_reg <= {quo_b_reg[21:0], fit_b};
        end
    end

    assign done  = done_reg;
    assign quo_a = quo_a_reg;
    assign quo_b = quo_b_reg;

endmodule

`default_nettype wire

// File: hdl/crb_datapath.sv
// ----------------------------------------------------------------------------
// Resonator bank datapath
// Coefficient and state memories, shared complex multiply stages, squaring,
// square root and normalizing divider, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crb_datapath
    import crb_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire crb_pkg::dp_cmd_t          cmd,
    output crb_pkg::dp_stat_t              stat,
    input  wire logic signed [15:0]        s_sample,
    input  wire logic [crb_pkg::IDX_W-1:0] s_index,
    input  wire logic signed [17:0]        s_cos_step,
    input  wire logic signed [17:0]        s_sin_step,
    input  wire logic [15:0]               s_alpha,
    input  wire logic [15:0]               s_beta,
    output logic [crb_pkg::IDX_W-1:0]      m_resonator,
    output logic [61:0]                    m_power,
    output logic [30:0]                    m_amplitude
);

    // Captured item
    logic signed [15:0] sample_reg;
    logic [IDX_W-1:0]   index_reg;
    logic signed [17:0] cos_in_reg;
    logic signed [17:0] sin_in_reg;
    logic [15:0]        alpha_in_reg;
    logic [15:0]        beta_in_reg;

    // Memories
    logic               coef_we;
    logic [COEF_W-1:0]  coef_wdata;
    logic [COEF_W-1:0]  coef_rd;
    logic               st_we;
    logic [STATE_W-1:0] st_wdata;
    logic [STATE_W-1:0] st_rd;

    // Fields of the stored words
    logic signed [23:0] zr;
    logic signed [23:0] zi;
    logic signed [31:0] r_re;
    logic signed [31:0] r_im;
    logic signed [31:0] rr_re;
    logic signed [31:0] rr_im;
    logic signed [17:0] w_re;
    logic signed [17:0] w_im;
    logic [15:0]        alpha;
    logic [15:0]        beta;
    logic signed [16:0] alpha_s;
    logic signed [16:0] beta_s;
    logic signed [17:0] oma;
    logic signed [17:0] omb;

    // Sample pipeline registers
    logic signed [32:0] ax_reg;
    logic signed [41:0] zrwr_reg;
    logic signed [41:0] ziwi_reg;
    logic signed [41:0] zrwi_reg;
    logic signed [41:0] ziwr_reg;
    logic signed [49:0] roma_re_reg;
    logic signed [49:0] roma_im_reg;
    logic signed [49:0] rroma_re_reg;
    logic signed [49:0] rroma_im_reg;
    logic signed [56:0] zax_re_reg;
    logic signed [56:0] zax_im_reg;
    logic signed [23:0] zn_re_reg;
    logic signed [23:0] zn_im_reg;
    logic signed [31:0] rn_re_reg;
    logic signed [31:0] rn_im_reg;
    logic signed [48:0] rb_re_reg;
    logic signed [48:0] rb_im_reg;

    logic signed [42:0] zt_re;
    logic signed [42:0] zt_im;
    logic signed [23:0] zn_re_next;
    logic signed [23:0] zn_im_next;
    logic signed [58:0] rt_re;
    logic signed [58:0] rt_im;
    logic signed [31:0] rn_re_next;
    logic signed [31:0] rn_im_next;
    logic signed [50:0] rrt_re;
    logic signed [50:0] rrt_im;
    logic signed [31:0] rrn_re;
    logic signed [31:0] rrn_im;

    // Squaring and magnitude
    logic signed [31:0] sq_src_a;
    logic signed [31:0] sq_src_b;
    logic signed [63:0] sq_a_reg;
    logic signed [63:0] sq_b_reg;
    logic [63:0]        sum_reg;

    // Iterative units
    logic               sqrt_done;
    logic [31:0]        sqrt_root;
    logic               div_done;
    logic [22:0]        quo_a;
    logic [22:0]        quo_b;
    logic [23:0]        q;
    logic [23:0]        zr_mag;
    logic [23:0]        zi_mag;
    logic [45:0]        num_a;
    logic [45:0]        num_b;
    logic signed [23:0] nz_re;
    logic signed [23:0] nz_im;

    // Result register
    logic [IDX_W-1:0]   res_idx_reg;
    logic [61:0]        power_reg;
    logic [30:0]        amp_reg;

    crb_ram #(.WIDTH(COEF_W), .DEPTH(NUM_RES)) u_coef_ram (
        .aclk    (aclk),
        .we      (coef_we),
        .wr_addr (cmd.addr),
        .wr_data (coef_wdata),
        .rd_addr (cmd.addr),
        .rd_data (coef_rd)
    );

    crb_ram #(.WIDTH(STATE_W), .DEPTH(NUM_RES)) u_state_ram (
        .aclk    (aclk),
        .we      (st_we),
        .wr_addr (cmd.addr),
        .wr_data (st_wdata),
        .rd_addr (cmd.addr),
        .rd_data (st_rd)
    );

    crb_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.op == DP_SQRT_GO),
        .radicand (sum_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    crb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.op == DP_DIV_GO),
        .num_a   (num_a),
        .num_b   (num_b),
        .den     (q),
        .done    (div_done),
        .quo_a   (quo_a),
        .quo_b   (quo_b)
    );

    // Unpack stored words; the read address is held for a whole update
    always_comb begin
        zr      = st_rd[23:0];
        zi      = st_rd[47:24];
        r_re    = st_rd[79:48];
        r_im    = st_rd[111:80];
        rr_re   = st_rd[143:112];
        rr_im   = st_rd[175:144];
        w_re    = coef_rd[17:0];
        w_im    = coef_rd[35:18];
        alpha   = coef_rd[51:36];
        beta    = coef_rd[67:52];
        alpha_s = signed'({1'b0, alpha});
        beta_s  = signed'({1'b0, beta});
        oma     = signed'({1'b0, 17'(17'h10000 - {1'b0, alpha})});
        omb     = signed'({1'b0, 17'(17'h10000 - {1'b0, beta})});
    end

    // Round and saturate the stage results
    always_comb begin
        zt_re      = 43'(zrwr_reg) - 43'(ziwi_reg) + 43'sd32768;
        zt_im      = 43'(zrwi_reg) + 43'(ziwr_reg) + 43'sd32768;
        zn_re_next = sat24(64'(zt_re >>> 16));
        zn_im_next = sat24(64'(zt_im >>> 16));
        rt_re      = (59'(roma_re_reg) <<< 8) + 59'(zax_re_reg) + 59'sd8388608;
        rt_im      = (59'(roma_im_reg) <<< 8) + 59'(zax_im_reg) + 59'sd8388608;
        rn_re_next = sat32(64'(rt_re >>> 24));
        rn_im_next = sat32(64'(rt_im >>> 24));
        rrt_re     = 51'(rroma_re_reg) + 51'(rb_re_reg) + 51'sd32768;
        rrt_im     = 51'(rroma_im_reg) + 51'(rb_im_reg) + 51'sd32768;
        rrn_re     = sat32(64'(rrt_re >>> 16));
        rrn_im     = sat32(64'(rrt_im >>> 16));
    end

    // Normalize: round(|z| * 2^22 / q), ties away from zero
    always_comb begin
        q      = sqrt_root[23:0];
        zr_mag = zr[23] ? 24'(-zr) : zr;
        zi_mag = zi[23] ? 24'(-zi) : zi;
        num_a  = {zr_mag, 22'b0} + 46'(q >> 1);
        num_b  = {zi_mag, 22'b0} + 46'(q >> 1);
        nz_re  = zr[23] ? -signed'({1'b0, quo_a}) : signed'({1'b0, quo_a});
        nz_im  = zi[23] ? -signed'({1'b0, quo_b}) : signed'({1'b0, quo_b});
    end

    // Squaring sources: phasor or smoothed output, zero for unloaded reads
    always_comb begin
        if (cmd.op == DP_SQR_Z) begin
            sq_src_a = 32'(zr);
            sq_src_b = 32'(zi);
        end else if (cmd.zero) begin
            sq_src_a = '0;
            sq_src_b = '0;
        end else begin
            sq_src_a = rr_re;
            sq_src_b = rr_im;
        end
    end

    // Memory writes
    always_comb begin
        coef_we    = (cmd.op == DP_LOAD);
        coef_wdata = {beta_in_reg, alpha_in_reg, sin_in_reg, cos_in_reg};
        st_we      = 1'b0;
        st_wdata   = '0;
        case (cmd.op)
            DP_LOAD: begin
                st_we    = 1'b1;
                st_wdata = {128'b0, 24'sd0, 24'sh400000};
            end
            DP_SMP_WR: begin
                st_we    = 1'b1;
                st_wdata = {rrn_im, rrn_re, rn_im_reg, rn_re_reg, zn_im_reg, zn_re_reg};
            end
            DP_STB_WR: begin
                st_we    = 1'b1;
                st_wdata = {st_rd[175:48], nz_im, nz_re};
            end
            default: begin
                st_we = 1'b0;
            end
        endcase
    end

    // Item capture
    always_ff @(posedge aclk) begin
        if (cmd.op == DP_CAPTURE) begin
            sample_reg   <= s_sample;
            index_reg    <= s_index;
            cos_in_reg   <= s_cos_step;
            sin_in_reg   <= s_sin_step;
            alpha_in_reg <= s_alpha;
            beta_in_reg  <= s_beta;
        end
    end

    // Sample update stages
    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_SMP_MUL1: begin
                ax_reg       <= alpha_s * sample_reg;
                zrwr_reg     <= zr * w_re;
                ziwi_reg     <= zi * w_im;
                zrwi_reg     <= zr * w_im;
                ziwr_reg     <= zi * w_re;
                roma_re_reg  <= r_re * oma;
                roma_im_reg  <= r_im * oma;
                rroma_re_reg <= rr_re * omb;
                rroma_im_reg <= rr_im * omb;
            end
            DP_SMP_MUL2: begin
                zax_re_reg <= zr * ax_reg;
                zax_im_reg <= zi * ax_reg;
                zn_re_reg  <= zn_re_next;
                zn_im_reg  <= zn_im_next;
            end
            DP_SMP_RES: begin
                rn_re_reg <= rn_re_next;
                rn_im_reg <= rn_im_next;
            end
            DP_SMP_MUL3: begin
                rb_re_reg <= rn_re_reg * beta_s;
                rb_im_reg <= rn_im_reg * beta_s;
            end
            default: begin
            end
        endcase
    end

    // Squares, their sum and the result register
    always_ff @(posedge aclk) begin
        if (cmd.op == DP_SQR_Z || cmd.op == DP_SQR_RR) begin
            sq_a_reg <= sq_src_a * sq_src_a;
            sq_b_reg <= sq_src_b * sq_src_b;
        end
        if (cmd.op == DP_SUM) begin
            sum_reg <= unsigned'(sq_a_reg) + unsigned'(sq_b_reg);
        end
        if (cmd.op == DP_OUT) begin
            res_idx_reg <= index_reg;
            power_reg   <= (sum_reg[63:62] != 2'b00) ? '1 : sum_reg[61:0];
            amp_reg     <= sqrt_root[31] ? '1 : sqrt_root[30:0];
        end
    end

    assign stat.m_zero    = (sum_reg == '0);
    assign stat.sqrt_done = sqrt_done;
    assign stat.div_done  = div_done;

    assign m_resonator = res_idx_reg;
    assign m_power     = power_reg;
    assign m_amplitude = amp_reg;

endmodule

`default_nettype wire

// File: hdl/crb_ctrl.sv
// ----------------------------------------------------------------------------
// Resonator bank controller
// Item handshake, loaded flags, sweep over the bank and datapath sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "complex_resonator_bank_assert.svh"

module crb_ctrl
    import crb_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [1:0]                s_operation,
    input  wire logic [crb_pkg::IDX_W-1:0] s_index,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output crb_pkg::dp_cmd_t               cmd,
    input  wire crb_pkg::dp_stat_t         stat
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CHK,
        ST_SMP1,
        ST_SMP2,
        ST_SMP3,
        ST_SMP4,
        ST_SMP5,
        ST_STB1,
        ST_STB2,
        ST_STB3,
        ST_STB4,
        ST_STB5,
        ST_STB6,
        ST_STB7,
        ST_NEXT,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_RD4,
        ST_RD5
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                stab_reg;
    logic [NUM_RES-1:0]  loaded_reg;
    logic                m_valid_reg;
    logic                accept;
    logic                out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            addr_reg    <= '0;
            stab_reg    <= 1'b0;
            loaded_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // Drop the result once taken; the read state sets it itself
            if (m_valid_reg && m_ready && state_reg != ST_RD5) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        stab_reg <= (s_operation == OP_STABILIZE);
                        case (s_operation)
                            OP_LOAD: begin
                                addr_reg  <= ADDR_W'(s_index);
                                state_reg <= idx_in_range(s_index) ? ST_LOAD : ST_IDLE;
                            end
                            OP_READ: begin
                                addr_reg  <= ADDR_W'(s_index);
                                state_reg <= idx_in_range(s_index) ? ST_RD0 : ST_IDLE;
                            end
                            default: begin
                                addr_reg  <= '0;
                                state_reg <= ST_CHK;
                            end
                        endcase
                    end
                end
                ST_LOAD: begin
                    loaded_reg[addr_reg] <= 1'b1;
                    state_reg            <= ST_IDLE;
                end
                // Skip resonators that were never loaded
                ST_CHK: begin
                    if (!loaded_reg[addr_reg]) begin
                        state_reg <= ST_NEXT;
                    end else begin
                        state_reg <= stab_reg ? ST_STB1 : ST_SMP1;
                    end
                end
                ST_SMP1: state_reg <= ST_SMP2;
                ST_SMP2: state_reg <= ST_SMP3;
                ST_SMP3: state_reg <= ST_SMP4;
                ST_SMP4: state_reg <= ST_SMP5;
                ST_SMP5: state_reg <= ST_NEXT;
                ST_STB1: state_reg <= ST_STB2;
                ST_STB2: state_reg <= ST_STB3;
                // Leave a zero phasor as it is
                ST_STB3: state_reg <= stat.m_zero ? ST_NEXT : ST_STB4;
                ST_STB4: begin
                    if (stat.sqrt_done) begin
                        state_reg <= ST_STB5;
                    end
                end
                ST_STB5: state_reg <= ST_STB6;
                ST_STB6: begin
                    if (stat.div_done) begin
                        state_reg <= ST_STB7;
                    end
                end
                ST_STB7: state_reg <= ST_NEXT;
                // Advance the sweep, drop back to idle after the last resonator
                ST_NEXT: begin
                    if (addr_reg == ADDR_W'(NUM_RES - 1)) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        addr_reg  <= addr_reg + ADDR_W'(1);
                        state_reg <= ST_CHK;
                    end
                end
                ST_RD0: state_reg <= ST_RD1;
                ST_RD1: state_reg <= ST_RD2;
                ST_RD2: state_reg <= ST_RD3;
                ST_RD3: state_reg <= ST_RD4;
                ST_RD4: begin
                    if (stat.sqrt_done) begin
                        state_reg <= ST_RD5;
                    end
                end
                // Hold until the result register is free
                ST_RD5: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath commands
    always_comb begin
        cmd.addr = addr_reg;
        cmd.zero = !loaded_reg[addr_reg];
        case (state_reg)
            ST_IDLE: cmd.op = accept ? DP_CAPTURE : DP_NOP;
            ST_LOAD: cmd.op = DP_LOAD;
            ST_SMP1: cmd.op = DP_SMP_MUL1;
            ST_SMP2: cmd.op = DP_SMP_MUL2;
            ST_SMP3: cmd.op = DP_SMP_RES;
            ST_SMP4: cmd.op = DP_SMP_MUL3;
            ST_SMP5: cmd.op = DP_SMP_WR;
            ST_STB1: cmd.op = DP_SQR_Z;
            ST_STB2: cmd.op = DP_SUM;
            ST_STB3: cmd.op = stat.m_zero ? DP_NOP : DP_SQRT_GO;
            ST_STB5: cmd.op = DP_DIV_GO;
            ST_STB7: cmd.op = DP_STB_WR;
            ST_RD1:  cmd.op = DP_SQR_RR;
            ST_RD2:  cmd.op = DP_SUM;
            ST_RD3:  cmd.op = DP_SQRT_GO;
            ST_RD5:  cmd.op = out_free ? DP_OUT : DP_NOP;
            default: cmd.op = DP_NOP;
        endcase
    end

    `CRB_ASSERT_IMP(a_sqrt_done_waited, aclk, aresetn, stat.sqrt_done, (state_reg == ST_STB4 || state_reg == ST_RD4))
    `CRB_ASSERT_IMP(a_div_done_waited, aclk, aresetn, stat.div_done, (state_reg == ST_STB6))
    `CRB_ASSERT_NXT(a_load_marks, aclk, aresetn, (state_reg == ST_LOAD), loaded_reg[$past(addr_reg)])

endmodule

`default_nettype wire

// File: hdl/complex_resonator_bank.sv
// ----------------------------------------------------------------------------
// Complex resonator bank
// Bank of complex resonators with load, sample, stabilize and read items.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  s_       | in        | s_valid / s_ready  | operation, sample, index, steps, weights
//  m_       | out       | m_valid / m_ready  | resonator, power, amplitude
//
// Load writes one resonator. Sample and stabilize sweep the bank one resonator at a time
// (shared multiply stages, one state memory address) and skip unloaded resonators;
// stabilize leaves a zero phasor as it is, else waits on the square root and divider units.
// Read waits on the square root unit, plus any m_ready stall on a pending result.
// Reset is synchronous on aresetn and clears all loaded flags; no clearing pass.
// A pending result holds in the output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none

module complex_resonator_bank
    import crb_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [1:0]                s_operation,
    input  wire logic signed [15:0]        s_sample,
    input  wire logic [crb_pkg::IDX_W-1:0] s_index,
    input  wire logic signed [17:0]        s_cos_step,
    input  wire logic signed [17:0]        s_sin_step,
    input  wire logic [15:0]               s_alpha,
    input  wire logic [15:0]               s_beta,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [crb_pkg::IDX_W-1:0]      m_resonator,
    output logic [61:0]                    m_power,
    output logic [30:0]                    m_amplitude
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    crb_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_index     (s_index),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .stat        (stat)
    );

    crb_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_sample    (s_sample),
        .s_index     (s_index),
        .s_cos_step  (s_cos_step),
        .s_sin_step  (s_sin_step),
        .s_alpha     (s_alpha),
        .s_beta      (s_beta),
        .m_resonator (m_resonator),
        .m_power     (m_power),
        .m_amplitude (m_amplitude)
    );

endmodule

`default_nettype wire

// File: bench/complex_resonator_bank_test.sv
// ----------------------------------------------------------------------------
// Complex resonator bank testbench
// Drives load, sample, stabilize and read items with random bursts and gaps.
// A built-in fixed-point model of the bank predicts every read, and each read
// is compared field by field against the oldest predicted read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_resonator_bank_test;
    import crb_pkg::*;

    localparam int  BANK_SIZE  = 64;
    localparam int  IDLE_LIMIT = 20000;
    localparam int  RAND_ITEMS = 1630;

    typedef struct {
        logic [5:0]  resonator;
        logic [61:0] power;
        logic [30:0] amplitude;
    } readout_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_operation;
    logic signed [15:0] s_sample;
    logic [5:0]         s_index;
    logic signed [17:0] s_cos_step;
    logic signed [17:0] s_sin_step;
    logic [15:0]        s_alpha;
    logic [15:0]        s_beta;
    logic               m_valid;
    logic               m_ready;
    logic [5:0]         m_resonator;
    logic [61:0]        m_power;
    logic [30:0]        m_amplitude;

    // Model state of the bank
    longint   w_cos [BANK_SIZE];
    longint   w_sin [BANK_SIZE];
    longint   wt_alpha [BANK_SIZE];
    longint   wt_beta [BANK_SIZE];
    bit       is_loaded [BANK_SIZE];
    longint   z_re [BANK_SIZE];
    longint   z_im [BANK_SIZE];
    longint   r_re [BANK_SIZE];
    longint   r_im [BANK_SIZE];
    longint   rr_re [BANK_SIZE];
    longint   rr_im [BANK_SIZE];

    readout_t pending_reads[$];
    int       mismatches;
    int       burst_left;
    int       idle_cycles;
    int       ready_phase;

    complex_resonator_bank dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_sample    (s_sample),
        .s_index     (s_index),
        .s_cos_step  (s_cos_step),
        .s_sin_step  (s_sin_step),
        .s_alpha     (s_alpha),
        .s_beta      (s_beta),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_resonator (m_resonator),
        .m_power     (m_power),
        .m_amplitude (m_amplitude)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Arithmetic helpers: round to nearest, ties up, then clamp
    function automatic longint round_sh(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(input longint v, input int bits);
        longint hi;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        if (v > hi) begin
            return hi;
        end else if (v < -hi - 1) begin
            return -hi - 1;
        end
        return v;
    endfunction

    function automatic bit [63:0] int_sqrt(input bit [63:0] n);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unit_half(input longint c, input bit [63:0] q);
        bit [63:0] mag;
        longint    v;
        mag = (c < 0) ? 64'(-c) : 64'(c);
        mag = mag << 22;
        v = longint'((mag + q / 2) / q);
        if (c < 0) v = -v;
        return clamp(v, 24);
    endfunction

    // Advance the bank model by one accepted item; queue a read result
    task automatic bank_update(input logic [1:0] op, input longint x, input int idx,
                               input longint c, input longint s,
                               input longint a, input longint b);
        longint    zr, zi, oma, omb, ax;
        bit [63:0] m, q, p, amp;
        readout_t  ro;
        case (op)
            OP_SAMPLE: begin
                for (int i = 0; i < BANK_SIZE; i++) begin
                    if (is_loaded[i]) begin
                        zr = z_re[i];
                        zi = z_im[i];
                        oma = 65536 - wt_alpha[i];
                        omb = 65536 - wt_beta[i];
                        ax = wt_alpha[i] * x;
                        r_re[i] = clamp(round_sh(r_re[i] * oma * 256 + zr * ax, 24), 32);
                        r_im[i] = clamp(round_sh(r_im[i] * oma * 256 + zi * ax, 24), 32);
                        rr_re[i] = clamp(round_sh(rr_re[i] * omb + r_re[i] * wt_beta[i], 16), 32);
                        rr_im[i] = clamp(round_sh(rr_im[i] * omb + r_im[i] * wt_beta[i], 16), 32);
                        z_re[i] = clamp(round_sh(zr * w_cos[i] - zi * w_sin[i], 16), 24);
                        z_im[i] = clamp(round_sh(zr * w_sin[i] + zi * w_cos[i], 16), 24);
                    end
                end
            end
            OP_LOAD: begin
                w_cos[idx] = c;
                w_sin[idx] = s;
                wt_alpha[idx] = a;
                wt_beta[idx] = b;
                is_loaded[idx] = 1'b1;
                z_re[idx] = 64'sd1 <<< 22;
                z_im[idx] = 0;
                r_re[idx] = 0;
                r_im[idx] = 0;
                rr_re[idx] = 0;
                rr_im[idx] = 0;
            end
            OP_STABILIZE: begin
                // Zero phasors stay as they are
                for (int i = 0; i < BANK_SIZE; i++) begin
                    if (is_loaded[i]) begin
                        m = 64'(z_re[i] * z_re[i]) + 64'(z_im[i] * z_im[i]);
                        if (m != 0) begin
                            q = int_sqrt(m);
                            z_re[i] = unit_half(z_re[i], q);
                            z_im[i] = unit_half(z_im[i], q);
                        end
                    end
                end
            end
            default: begin
                p = 64'(rr_re[idx] * rr_re[idx]) + 64'(rr_im[idx] * rr_im[idx]);
                amp = int_sqrt(p);
                ro.resonator = 6'(idx);
                ro.power = (p > 64'h3FFF_FFFF_FFFF_FFFF) ? '1 : p[61:0];
                ro.amplitude = (amp > 64'h7FFF_FFFF) ? '1 : amp[30:0];
                pending_reads.push_back(ro);
            end
        endcase
    endtask

    // Send one item, hold it until accepted, then maybe open a gap
    task automatic send_item(input logic [1:0] op, input logic signed [15:0] x,
                             input logic [5:0] idx, input logic signed [17:0] c,
                             input logic signed [17:0] s, input logic [15:0] a,
                             input logic [15:0] b);
        s_valid     <= 1'b1;
        s_operation <= op;
        s_sample    <= x;
        s_index     <= idx;
        s_cos_step  <= c;
        s_sin_step  <= s;
        s_alpha     <= a;
        s_beta      <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bank_update(op, longint'(x), int'(idx), longint'(c), longint'(s),
                    longint'(a), longint'(b));
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 16);
        end
    endtask

    task automatic send_simple(input logic [1:0] op, input logic [5:0] idx);
        send_item(op, 16'($urandom), idx, 18'($urandom), 18'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    // Reads of never-loaded resonators report zero
    task automatic test_unloaded_read();
        send_simple(OP_READ, 6'd0);
        send_simple(OP_READ, 6'd63);
    endtask

    // Loads at the weight and step extremes, samples at the sample extremes
    task automatic test_load_and_sample();
        send_item(OP_LOAD, 16'sd0, 6'd0, 18'sd58982, 18'sd28557, 16'h4000, 16'h2000);
        send_item(OP_LOAD, 16'sd0, 6'd63, 18'sd131071, 18'sd131071, 16'hFFFF, 16'hFFFF);
        send_item(OP_LOAD, 16'sd0, 6'd5, 18'sd0, 18'sd0, 16'h0000, 16'h0000);
        send_item(OP_LOAD, 16'sd0, 6'd7, -18'sd131072, -18'sd131072, 16'hFFFF, 16'h0001);
        send_simple(OP_SAMPLE, 6'd0);
        send_item(OP_SAMPLE, 16'sd32767, 6'd0, 18'sd0, 18'sd0, 16'h0, 16'h0);
        send_item(OP_SAMPLE, -16'sd32768, 6'd0, 18'sd0, 18'sd0, 16'h0, 16'h0);
        send_item(OP_SAMPLE, -16'sd32768, 6'd0, 18'sd0, 18'sd0, 16'h0, 16'h0);
        send_item(OP_SAMPLE, 16'sd0, 6'd0, 18'sd0, 18'sd0, 16'h0, 16'h0);
        send_simple(OP_READ, 6'd0);
        send_simple(OP_READ, 6'd63);
        send_simple(OP_READ, 6'd5);
        send_simple(OP_READ, 6'd7);
    endtask

    // Stabilize grown, shrunk and zero phasors
    task automatic test_stabilize();
        send_simple(OP_STABILIZE, 6'd0);
        send_item(OP_SAMPLE, 16'sd32767, 6'd0, 18'sd0, 18'sd0, 16'h0, 16'h0);
        send_simple(OP_READ, 6'd63);
        send_simple(OP_STABILIZE, 6'd0);
        send_item(OP_SAMPLE, -16'sd32768, 6'd0, 18'sd0, 18'sd0, 16'h0, 16'h0);
        send_simple(OP_READ, 6'd0);
        send_simple(OP_READ, 6'd7);
    endtask

    // Random mix: mostly samples and reads, at random resonator indices
    task automatic test_random_mix();
        int          pick;
        logic [15:0] x;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            pick = $urandom_range(99);
            case ($urandom_range(7))
                0: x = 16'h7FFF;
                1: x = 16'h8000;
                default: x = 16'($urandom);
            endcase
            if (pick < 12) begin
                send_simple(OP_LOAD, 6'($urandom));
            end else if (pick < 62) begin
                send_item(OP_SAMPLE, x, 6'($urandom), 18'($urandom), 18'($urandom),
                          16'($urandom), 16'($urandom));
            end else if (pick < 97) begin
                send_simple(OP_READ, 6'($urandom));
            end else begin
                send_simple(OP_STABILIZE, 6'($urandom));
            end
        end
    endtask

    // Receiver: free-flowing stretches alternate with random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b0;
            ready_phase <= 0;
        end else begin
            ready_phase <= ready_phase + 1;
            if (ready_phase[6]) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(2) != 0);
            end
        end
    end

    // Check each result against the oldest predicted read
    always @(posedge aclk) begin
        readout_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reads.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: resonator %0d power %h amplitude %h",
                             m_resonator, m_power, m_amplitude);
            end else begin
                want = pending_reads.pop_front();
                if (m_resonator !== want.resonator || m_power !== want.power ||
                    m_amplitude !== want.amplitude) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp res %0d pow %h amp %h, got res %0d pow %h amp %h",
                                 want.resonator, want.power, want.amplitude,
                                 m_resonator, m_power, m_amplitude);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** complex_resonator_bank: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        mismatches  = 0;
        burst_left  = 4;
        for (int i = 0; i < BANK_SIZE; i++) begin
            w_cos[i] = 0;
            w_sin[i] = 0;
            wt_alpha[i] = 0;
            wt_beta[i] = 0;
            is_loaded[i] = 1'b0;
            z_re[i] = 64'sd1 <<< 22;
            z_im[i] = 0;
            r_re[i] = 0;
            r_im[i] = 0;
            rr_re[i] = 0;
            rr_im[i] = 0;
        end
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_operation = OP_SAMPLE;
        s_sample    = '0;
        s_index     = '0;
        s_cos_step  = '0;
        s_sin_step  = '0;
        s_alpha     = '0;
        s_beta      = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unloaded_read();
        test_load_and_sample();
        test_stabilize();
        test_random_mix();

        // Drain outstanding reads, then let the block settle
        s_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0) begin
            $display("** complex_resonator_bank: PASSED **");
        end else begin
            $display("** complex_resonator_bank: FAILED **");
        end
        $finish;
    end

endmodule
